[rtl/ifd_pkg.sv]
// ----------------------------------------------------------------------------
// ifd_pkg
// Shared constants and types of the interleaved FIR decimator: field widths,
// history row layout, the token passed along the multiply-accumulate chain
// and the configuration register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package ifd_pkg;

  localparam int IFD_CHANNELS = 16;   // default channel count
  localparam int HIST_LEN     = 6;    // earlier samples kept per channel
  localparam int SAMPLE_W     = 16;
  localparam int CH_FIELD_W   = 4;
  localparam int COEF_W       = 16;
  localparam int PAIR_W       = SAMPLE_W + 1;
  localparam int PROD_W       = COEF_W + PAIR_W;
  localparam int ACC_W        = 36;
  localparam int TAPS         = 4;    // distinct coefficients of the symmetric filter
  localparam int OUT_SHIFT    = 16;
  localparam int CNT_W        = 3;

  localparam logic [CNT_W-1:0]        CNT_FULL   = CNT_W'(HIST_LEN);
  localparam logic signed [ACC_W-1:0] ROUND_BIAS = ACC_W'(32'h0000_8000);

  // Row of one channel's history, element 0 is the oldest sample.
  typedef logic [HIST_LEN-1:0][SAMPLE_W-1:0] ifd_row_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_COEF_OUTER  = 2'd0,
    CFG_COEF_SECOND = 2'd1,
    CFG_COEF_THIRD  = 2'd2,
    CFG_COEF_CENTRE = 2'd3
  } ifd_cfg_idx_t;

  // Token travelling through the accumulate chain.
  typedef struct packed {
    logic                          vld;
    logic [CH_FIELD_W-1:0]         ch;
    logic [TAPS-1:0][PAIR_W-1:0]   pairs;
    logic signed [ACC_W-1:0]       acc;
  } ifd_tok_t;

endpackage

`default_nettype wire

[rtl/ifd_in_if.sv]
// ----------------------------------------------------------------------------
// ifd_in_if
// Sample channel: one channel-tagged sample per item, valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface ifd_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ifd_pkg::SAMPLE_W-1:0]  sample;
  logic [ifd_pkg::CH_FIELD_W-1:0]       channel;
  logic                                 start_block;

  modport source (output valid, output sample, output channel, output start_block,
                  input ready);
  modport sink   (input valid, input sample, input channel, input start_block,
                  output ready);
endinterface

`default_nettype wire

[rtl/ifd_out_if.sv]
// ----------------------------------------------------------------------------
// ifd_out_if
// Result channel: one filtered, decimated sample per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ifd_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ifd_pkg::SAMPLE_W-1:0]  filtered;
  logic [ifd_pkg::CH_FIELD_W-1:0]       out_channel;

  modport source (output valid, output filtered, output out_channel, input ready);
  modport sink   (input valid, input filtered, input out_channel, output ready);
endinterface

`default_nettype wire

[rtl/ifd_cell.sv]
// ----------------------------------------------------------------------------
// ifd_cell
// One multiply-accumulate cell: adds coef * pair[IDX] to the running sum and
// hands the token to the next cell. Holds while its output is not taken.
// ----------------------------------------------------------------------------
`default_nettype none

module ifd_cell #(
  parameter int IDX = 0
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic signed [ifd_pkg::COEF_W-1:0]    coef,
  input  wire ifd_pkg::ifd_tok_t                    tok_i,
  output      logic                                 rdy_o,
  output      ifd_pkg::ifd_tok_t                    tok_o,
  input  wire logic                                 rdy_i
);

  ifd_pkg::ifd_tok_t                      tok_r;
  ifd_pkg::ifd_tok_t                      tok_nxt;
  logic signed [ifd_pkg::PROD_W-1:0]      prod;

  assign prod = coef * $signed(tok_i.pairs[IDX]);

  always_comb begin
    tok_nxt     = tok_i;
    tok_nxt.acc = tok_i.acc + ifd_pkg::ACC_W'(prod);
  end

  // Advance when empty or when the neighbor takes the held token.
  assign rdy_o = !tok_r.vld || rdy_i;

  // Only the valid bit is reset; the payload of an empty slot is don't care.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else if (rdy_o) begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

`default_nettype wire

[rtl/ifd_front.sv]
// ----------------------------------------------------------------------------
// ifd_front
// Per-channel bookkeeping: set count and phase in flip-flops, sample history
// in a memory read on accept and written back when stage 1 advances, with a
// bypass for a channel written in the same cycle it is read. Builds tap pairs.
// ----------------------------------------------------------------------------
`default_nettype none

module ifd_front #(
  parameter int CHANNELS = ifd_pkg::IFD_CHANNELS
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid,
  output      logic                                 in_ready,
  input  wire logic signed [ifd_pkg::SAMPLE_W-1:0]  in_sample,
  input  wire logic [ifd_pkg::CH_FIELD_W-1:0]       in_channel,
  input  wire logic                                 in_start,
  output      ifd_pkg::ifd_tok_t                    tok_o,
  input  wire logic                                 rdy_i
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [ifd_pkg::CNT_W-1:0]  cnt_r   [CHANNELS];
  logic                       phase_r [CHANNELS];
  ifd_pkg::ifd_row_t          mem     [CHANNELS];

  logic [CH_W-1:0]            idx;
  logic                       in_range;
  logic                       take;
  logic [ifd_pkg::CNT_W-1:0]  cnt_cur;
  logic                       phase_cur;
  logic                       emit;

  logic                                s1_vld_r;
  logic                                s1_emit_r;
  logic [CH_W-1:0]                     s1_idx_r;
  logic [ifd_pkg::CH_FIELD_W-1:0]      s1_ch_r;
  logic signed [ifd_pkg::SAMPLE_W-1:0] s1_sample_r;
  ifd_pkg::ifd_row_t                   rd_row_r;
  ifd_pkg::ifd_row_t                   fwd_row_r;
  logic                                fwd_hit_r;
  ifd_pkg::ifd_row_t                   row;
  ifd_pkg::ifd_row_t                   new_row;
  logic                                s1_adv;
  logic                                s1_wr;

  assign idx      = CH_W'(in_channel);
  assign in_range = 32'(in_channel) < CHANNELS;
  assign take     = in_valid && in_ready && in_range;

  // A start flag restarts count and phase before the item is taken.
  assign cnt_cur   = in_start ? '0   : cnt_r[idx];
  assign phase_cur = in_start ? 1'b0 : phase_r[idx];
  assign emit      = (cnt_cur >= ifd_pkg::CNT_FULL) && !phase_cur;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        cnt_r[i]   <= '0;
        phase_r[i] <= 1'b0;
      end
    end else if (take) begin
      cnt_r[idx]   <= (cnt_cur >= ifd_pkg::CNT_FULL) ? ifd_pkg::CNT_FULL
                                                     : cnt_cur + 1'b1;
      phase_r[idx] <= !phase_cur;
    end
  end

  // Stage 1 handshake.
  assign s1_adv   = !s1_emit_r || rdy_i;
  assign s1_wr    = s1_vld_r && s1_adv;
  assign in_ready = !s1_vld_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_ready) begin
      s1_vld_r <= in_valid && in_range;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_emit_r   <= emit;
      s1_idx_r    <= idx;
      s1_ch_r     <= in_channel;
      s1_sample_r <= in_sample;
      rd_row_r    <= mem[idx];
      fwd_hit_r   <= s1_wr && (s1_idx_r == idx);
      fwd_row_r   <= new_row;
    end
  end

  // History memory: read on accept, written back when stage 1 advances.
  always_ff @(posedge clk) begin
    if (s1_wr) begin
      mem[s1_idx_r] <= new_row;
    end
  end

  assign row     = fwd_hit_r ? fwd_row_r : rd_row_r;
  assign new_row = {s1_sample_r, row[ifd_pkg::HIST_LEN-1:1]};

  always_comb begin
    tok_o.vld      = s1_vld_r && s1_emit_r;
    tok_o.ch       = s1_ch_r;
    tok_o.acc      = ifd_pkg::ROUND_BIAS;
    tok_o.pairs[0] = ifd_pkg::PAIR_W'($signed(row[0])) + ifd_pkg::PAIR_W'(s1_sample_r);
    tok_o.pairs[1] = ifd_pkg::PAIR_W'($signed(row[1])) + ifd_pkg::PAIR_W'($signed(row[5]));
    tok_o.pairs[2] = ifd_pkg::PAIR_W'($signed(row[2])) + ifd_pkg::PAIR_W'($signed(row[4]));
    tok_o.pairs[3] = ifd_pkg::PAIR_W'($signed(row[3]));
  end

endmodule

`default_nettype wire

[rtl/interleaved_fir_decimator_unit.sv]
// ----------------------------------------------------------------------------
// interleaved_fir_decimator_unit
// Symmetric 7-tap FIR decimator by two over channel-interleaved samples.
// Per channel it keeps six earlier samples, counts sets since the last start
// flag and, from set six on, emits a rounded result on every even set.
// ----------------------------------------------------------------------------
//
//   port      direction  payload                              accepted when
//   in_if     sink       sample, channel, start_block         valid && ready
//   out_if    source     filtered, out_channel                valid && ready
//   cfg_*     write      cfg_idx (coef index), cfg_wdata      cfg_we
//
// Throughput: one item per cycle unless a stalled output backs up into stage 1;
// a result passes the history read, then four multiply-accumulate cells, one
// coefficient each, before it leaves the output register.
// Reset: synchronous, active low; clears counts, phases, coefficients and
// the pipeline valid bits. History needs no clearing: no result is emitted
// before six samples have been written since reset or the last start flag.
// Stalls: each cell holds its token while the next cannot take it, so a
// waiting result does not block the input until the chain fills up.
// ----------------------------------------------------------------------------
`default_nettype none

module interleaved_fir_decimator_unit #(
  parameter int CHANNELS = ifd_pkg::IFD_CHANNELS
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  ifd_in_if.sink                                     in_if,
  ifd_out_if.source                                  out_if,
  input  wire logic                                  cfg_we,
  input  wire logic [1:0]                            cfg_idx,
  input  wire logic [ifd_pkg::COEF_W-1:0]            cfg_wdata
);

  // Coefficient registers, indexed outer, second, third, centre.
  logic [ifd_pkg::TAPS-1:0][ifd_pkg::COEF_W-1:0] coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
    end else if (cfg_we) begin
      unique case (ifd_pkg::ifd_cfg_idx_t'(cfg_idx))
        ifd_pkg::CFG_COEF_OUTER:  coef_r[0] <= cfg_wdata;
        ifd_pkg::CFG_COEF_SECOND: coef_r[1] <= cfg_wdata;
        ifd_pkg::CFG_COEF_THIRD:  coef_r[2] <= cfg_wdata;
        ifd_pkg::CFG_COEF_CENTRE: coef_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Token chain: tok[0] leaves the front end, tok[TAPS] is the output register.
  ifd_pkg::ifd_tok_t          tok [ifd_pkg::TAPS+1];
  logic [ifd_pkg::TAPS:0]     rdy;

  ifd_front #(
    .CHANNELS (CHANNELS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_if.valid),
    .in_ready   (in_if.ready),
    .in_sample  (in_if.sample),
    .in_channel (in_if.channel),
    .in_start   (in_if.start_block),
    .tok_o      (tok[0]),
    .rdy_i      (rdy[0])
  );

  // One cell per coefficient; each adds its product and passes the sum on.
  for (genvar k = 0; k < ifd_pkg::TAPS; k++) begin : g_cell
    ifd_cell #(
      .IDX (k)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .coef  ($signed(coef_r[k])),
      .tok_i (tok[k]),
      .rdy_o (rdy[k]),
      .tok_o (tok[k+1]),
      .rdy_i (rdy[k+1])
    );
  end

  assign rdy[ifd_pkg::TAPS] = out_if.ready;

  // Drop the rounding bits: result is bits 31..16 of the sum.
  assign out_if.valid       = tok[ifd_pkg::TAPS].vld;
  assign out_if.filtered    =
    tok[ifd_pkg::TAPS].acc[ifd_pkg::OUT_SHIFT +: ifd_pkg::SAMPLE_W];
  assign out_if.out_channel = tok[ifd_pkg::TAPS].ch;

endmodule

`default_nettype wire

[tb/sv/tb_interleaved_fir_decimator_unit.sv]
// ----------------------------------------------------------------------------
// tb_interleaved_fir_decimator_unit
// Self-checking bench for the interleaved 7-tap FIR decimator. A queue of
// channel-tagged samples feeds a clocked driver; every accepted item steps a
// per-channel filter model that queues the filtered samples it predicts. A
// clocked monitor compares each result item with the oldest prediction. The
// run walks through several coefficient sets, extremes included, with random
// idling on both channels except in the last set, and one long output stall.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_interleaved_fir_decimator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // One sample item as offered to the block.
  typedef struct packed {
    logic signed [ifd_pkg::SAMPLE_W-1:0] sample;
    logic [ifd_pkg::CH_FIELD_W-1:0]      channel;
    logic                                start_block;
  } sample_item_t;

  // One predicted filter output.
  typedef struct packed {
    logic signed [ifd_pkg::SAMPLE_W-1:0] filtered;
    logic [ifd_pkg::CH_FIELD_W-1:0]      channel;
  } filtered_item_t;

  localparam int DRAIN_CYCLES = 12;   // pipeline is five deep; leave margin
  localparam int HOLD_CYCLES  = 400;  // long receiver stall
  localparam int HOLD_AFTER   = 300;  // accepted items before the stall

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic                           cfg_we;
  logic [1:0]                     cfg_idx;
  logic [ifd_pkg::COEF_W-1:0]     cfg_wdata;

  ifd_in_if  in_bus ();
  ifd_out_if out_bus ();

  interleaved_fir_decimator_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_bus),
    .out_if    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Filter model: coefficients, per-channel history, set count and phase.
  // --------------------------------------------------------------------------
  logic signed [ifd_pkg::COEF_W-1:0]   coef_m  [ifd_pkg::TAPS];
  logic signed [ifd_pkg::SAMPLE_W-1:0] hist_m  [ifd_pkg::IFD_CHANNELS][ifd_pkg::HIST_LEN];
  logic [ifd_pkg::CNT_W-1:0]           count_m [ifd_pkg::IFD_CHANNELS];
  logic                                phase_m [ifd_pkg::IFD_CHANNELS];

  sample_item_t   sample_q   [$];   // items still to be offered
  filtered_item_t filtered_q [$];   // predicted outputs not yet seen

  int unsigned err_count    = 0;
  int unsigned accepted_cnt = 0;
  bit          idle_en;
  bit          out_hold;
  bit          offer_pending = 1'b0;

  // Advance one channel by one accepted sample; queue the output it causes.
  function automatic void filter_step(input sample_item_t it);
    int             ch;
    int             k;
    longint         acc;
    logic signed [ifd_pkg::SAMPLE_W-1:0] s;
    filtered_item_t res;
    ch = int'(it.channel);
    if (ch >= ifd_pkg::IFD_CHANNELS) return;
    // A start flag restarts the block before the sample is taken.
    if (it.start_block) begin
      count_m[ch] = '0;
      phase_m[ch] = 1'b0;
    end
    // Emit only with six earlier sets in the block and on an even set.
    if (count_m[ch] >= ifd_pkg::CNT_FULL && !phase_m[ch]) begin
      acc = 64'sh8000;
      for (k = 0; k < 7; k++) begin
        s = (k < ifd_pkg::HIST_LEN) ? hist_m[ch][k] : it.sample;
        // Taps mirror around the middle one.
        acc += longint'(coef_m[(k <= 3) ? k : 6 - k]) * longint'(s);
      end
      res.filtered = acc[31:16];
      res.channel  = it.channel;
      filtered_q.push_back(res);
    end
    for (k = 0; k < ifd_pkg::HIST_LEN - 1; k++) hist_m[ch][k] = hist_m[ch][k + 1];
    hist_m[ch][ifd_pkg::HIST_LEN-1] = it.sample;
    // Saturate the count; keep toggling the phase on long blocks.
    if (count_m[ch] < ifd_pkg::CNT_FULL) count_m[ch] = count_m[ch] + 1'b1;
    phase_m[ch] = ~phase_m[ch];
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offer queued items, hold each until accepted, idle in bursts.
  // --------------------------------------------------------------------------
  sample_item_t offer_item;
  int           in_gap = 0;
  bit           offering;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_gap = 0;
    end else begin
      offering = in_bus.valid;
      if (in_bus.valid && in_bus.ready) begin
        // Predict first, then drop the pending flag, so the drain check
        // never sees neither.
        filter_step(offer_item);
        accepted_cnt++;
        offer_pending = 1'b0;
        offering = 1'b0;
      end
      if (!offering) begin
        if (in_gap != 0) begin
          in_gap--;
          in_bus.valid <= 1'b0;
        end else if (sample_q.size() == 0) begin
          in_bus.valid <= 1'b0;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
          in_gap = $urandom_range(0, 15);
          in_bus.valid <= 1'b0;
        end else begin
          offer_item = sample_q.pop_front();
          offer_pending = 1'b1;
          in_bus.valid       <= 1'b1;
          in_bus.sample      <= offer_item.sample;
          in_bus.channel     <= offer_item.channel;
          in_bus.start_block <= offer_item.start_block;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: check each accepted result item, stall ready at random.
  // --------------------------------------------------------------------------
  filtered_item_t want;
  int             out_gap = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (filtered_q.size() == 0) begin
          $display("%0t: unexpected result, channel %0d filtered %h", $time,
                   out_bus.out_channel, out_bus.filtered);
          err_count++;
        end else begin
          want = filtered_q.pop_front();
          if (out_bus.filtered !== want.filtered) begin
            $display("%0t: filtered mismatch on channel %0d: expected %h actual %h",
                     $time, want.channel, want.filtered, out_bus.filtered);
            err_count++;
          end
          if (out_bus.out_channel !== want.channel) begin
            $display("%0t: out_channel mismatch: expected %0d actual %0d",
                     $time, want.channel, out_bus.out_channel);
            err_count++;
          end
        end
      end
      if (out_hold) begin
        out_bus.ready <= 1'b0;
      end else if (out_gap != 0) begin
        out_gap--;
        out_bus.ready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
        out_gap = $urandom_range(0, 15);
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  // Hold off the receiver once for a long stretch so the chain fills and
  // the input stalls while the driver keeps offering.
  initial begin
    out_hold = 1'b0;
    while (accepted_cnt < HOLD_AFTER) @(posedge clk);
    out_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    out_hold <= 1'b0;
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic write_coef(input ifd_pkg::ifd_cfg_idx_t idx,
                            input logic [ifd_pkg::COEF_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    coef_m[idx] = val;
  endtask

  // Write all four coefficients back to back, then release the write enable.
  task automatic load_coefs(input logic [ifd_pkg::COEF_W-1:0] c_outer,
                            input logic [ifd_pkg::COEF_W-1:0] c_second,
                            input logic [ifd_pkg::COEF_W-1:0] c_third,
                            input logic [ifd_pkg::COEF_W-1:0] c_centre);
    write_coef(ifd_pkg::CFG_COEF_OUTER,  c_outer);
    write_coef(ifd_pkg::CFG_COEF_SECOND, c_second);
    write_coef(ifd_pkg::CFG_COEF_THIRD,  c_third);
    write_coef(ifd_pkg::CFG_COEF_CENTRE, c_centre);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_sample(input logic [ifd_pkg::SAMPLE_W-1:0] s, input int ch,
                             input bit start);
    sample_item_t it;
    it.sample      = s;
    it.channel     = ifd_pkg::CH_FIELD_W'(ch);
    it.start_block = start;
    sample_q.push_back(it);
  endtask

  // Random interleaved stream over channels 0..ch_hi with rare restarts;
  // extremes show up about one sample in four.
  task automatic push_random(input int n, input int ch_hi, input int start_odds);
    int                           i;
    logic [ifd_pkg::SAMPLE_W-1:0] s;
    for (i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0:       s = 16'h8000;
        1:       s = 16'h7FFF;
        default: s = ifd_pkg::SAMPLE_W'($urandom);
      endcase
      push_sample(s, $urandom_range(0, ch_hi), $urandom_range(1, start_odds) == 1);
    end
  endtask

  // Wait until every item is in and every result is out, then let the
  // pipeline settle so a late no-result item cannot meet a register write.
  task automatic wait_drained();
    while (sample_q.size() != 0 || offer_pending || filtered_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int c;
    int j;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_idx            = ifd_pkg::CFG_COEF_OUTER;
    cfg_wdata          = '0;
    in_bus.valid       = 1'b0;
    in_bus.sample      = '0;
    in_bus.channel     = '0;
    in_bus.start_block = 1'b0;
    out_bus.ready      = 1'b0;
    idle_en            = 1'b1;
    for (c = 0; c < ifd_pkg::TAPS; c++) coef_m[c] = '0;
    for (c = 0; c < ifd_pkg::IFD_CHANNELS; c++) begin
      count_m[c] = '0;
      phase_m[c] = 1'b0;
      for (j = 0; j < ifd_pkg::HIST_LEN; j++) hist_m[c][j] = '0;
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extreme coefficients and samples on the two end channels,
    // interleaved. Channel 0 runs a long block (outputs at sets 6, 8, 10);
    // channel 15 gives one output and then restarts mid-block.
    load_coefs(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF);
    for (j = 0; j < 11; j++) begin
      push_sample(j[0] ? 16'h7FFF : 16'h8000, 0, j == 0);
      if (j < 8)
        push_sample(16'h7FFF, ifd_pkg::IFD_CHANNELS - 1, j == 0 || j == 7);
    end
    wait_drained();

    // Random phases, each with its own coefficient set.
    load_coefs(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    push_random(130, ifd_pkg::IFD_CHANNELS - 1, 40);
    wait_drained();

    load_coefs(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
    push_random(130, 3, 40);
    wait_drained();

    load_coefs(ifd_pkg::COEF_W'($urandom), ifd_pkg::COEF_W'($urandom),
               ifd_pkg::COEF_W'($urandom), ifd_pkg::COEF_W'($urandom));
    push_random(160, ifd_pkg::IFD_CHANNELS - 1, 30);
    wait_drained();

    load_coefs(ifd_pkg::COEF_W'($urandom), ifd_pkg::COEF_W'($urandom),
               ifd_pkg::COEF_W'($urandom), ifd_pkg::COEF_W'($urandom));
    push_random(160, 7, 20);
    wait_drained();

    // Last stretch runs back to back: no idling on either side.
    idle_en <= 1'b0;
    load_coefs(ifd_pkg::COEF_W'($urandom), ifd_pkg::COEF_W'($urandom),
               ifd_pkg::COEF_W'($urandom), ifd_pkg::COEF_W'($urandom));
    push_random(170, ifd_pkg::IFD_CHANNELS - 1, 40);
    wait_drained();

    if (err_count == 0 && filtered_q.size() == 0) begin
      $display("interleaved_fir_decimator_unit test passed");
    end else begin
      $display("interleaved_fir_decimator_unit test failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("interleaved_fir_decimator_unit test failed");
    $finish;
  end

endmodule

`default_nettype wire
